// File: src/rsa_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the reference-counted slot allocator.
// No dependencies; imported by rsa_apb_regs, rsa_engine and the top module.
package rsa_pkg;

	localparam int CODE_W   = 8;
	localparam int KEY_IN_W = 16;
	localparam int REF_W    = 16;
	localparam int STAT_W   = 3;
	localparam int MASK_W   = 32;
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;

	localparam logic [REF_W-1:0] REF_MAX = 16'hFFFF;

	localparam logic CMD_ACQUIRE = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	localparam logic [STAT_W-1:0] STAT_HIT       = 3'd0;
	localparam logic [STAT_W-1:0] STAT_NEW       = 3'd1;
	localparam logic [STAT_W-1:0] STAT_EXHAUSTED = 3'd2;
	localparam logic [STAT_W-1:0] STAT_HELD      = 3'd3;
	localparam logic [STAT_W-1:0] STAT_FREED     = 3'd4;
	localparam logic [STAT_W-1:0] STAT_UNKNOWN   = 3'd5;

	// Register indexes, selected by paddr[2]
	localparam logic REG_CODE_MIN = 1'b0;
	localparam logic REG_CODE_MAX = 1'b1;

	localparam logic [CODE_W-1:0] CODE_MIN_RST = 8'd1;
	localparam logic [CODE_W-1:0] CODE_MAX_RST = 8'd32;

	typedef struct packed {
		logic [CODE_W-1:0] code_min;
		logic [CODE_W-1:0] code_max;
	} cfg_t;

endpackage

// File: src/rsa_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module rsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: src/rsa_apb_regs.sv
`timescale 1ns / 1ps
// APB configuration registers: code_min and code_max.
// Depends on rsa_pkg.
module rsa_apb_regs
	import rsa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [CODE_W-1:0] code_min_q;
	logic [CODE_W-1:0] code_max_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_min_q <= CODE_MIN_RST;
			code_max_q <= CODE_MAX_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_CODE_MIN: code_min_q <= pwdata[CODE_W-1:0];
				REG_CODE_MAX: code_max_q <= pwdata[CODE_W-1:0];
				default:      code_min_q <= code_min_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_CODE_MIN: prdata = APB_DW'(code_min_q);
			REG_CODE_MAX: prdata = APB_DW'(code_max_q);
			default:      prdata = '0;
		endcase
	end

	assign cfg.code_min = code_min_q;
	assign cfg.code_max = code_max_q;

endmodule

// File: src/rsa_engine.sv
`timescale 1ns / 1ps
// Slot engine: scans the owner/count RAM for a key match and the lowest free
// slot, then updates the entry and the in-use bits. Depends on rsa_pkg, rsa_ram.
module rsa_engine
	import rsa_pkg::*;
#(
	parameter int SLOT_COUNT = 32,
	parameter int KEY_BITS   = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                command,
	input  logic [KEY_IN_W-1:0] owner_key,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [CODE_W-1:0]   code_value,
	output logic [STAT_W-1:0]   status,
	output logic [REF_W-1:0]    references,
	output logic [MASK_W-1:0]   active_mask
);

	localparam int KEY_W  = (KEY_BITS < KEY_IN_W) ? KEY_BITS : KEY_IN_W;
	localparam int IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
	localparam int DATA_W = KEY_W + REF_W;
	localparam logic [CNT_W-1:0] CNT_END = CNT_W'(SLOT_COUNT);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_UPDATE = 2'd2;

	logic [1:0]            state_q;
	logic                  cmd_q;
	logic [KEY_W-1:0]      key_q;
	logic [CNT_W-1:0]      rd_cnt_q;
	logic                  rd_v_s1;
	logic [IDX_W-1:0]      rd_idx_s1;
	logic                  found_q;
	logic [IDX_W-1:0]      hit_idx_q;
	logic [REF_W-1:0]      hit_refs_q;
	logic                  free_found_q;
	logic [IDX_W-1:0]      free_idx_q;
	logic [SLOT_COUNT-1:0] in_use_q;
	logic                  out_valid_q;

	logic                  rd_issue;
	logic [IDX_W-1:0]      rd_addr;
	logic [DATA_W-1:0]     rd_data;
	logic [KEY_W-1:0]      rd_owner;
	logic [REF_W-1:0]      rd_refs;
	logic                  rd_used;
	logic                  rd_hit;
	logic                  rd_in_range;
	logic [CODE_W-1:0]     eff_min;
	logic                  fire;

	logic                  upd_we;
	logic [IDX_W-1:0]      upd_idx;
	logic [REF_W-1:0]      upd_refs;
	logic [SLOT_COUNT-1:0] use_next;
	logic [CODE_W-1:0]     res_code;
	logic [STAT_W-1:0]     res_status;
	logic [REF_W-1:0]      res_refs;
	logic [REF_W-1:0]      inc_refs;
	logic [REF_W-1:0]      dec_refs;
	logic [CODE_W-1:0]     hit_code;
	logic [CODE_W-1:0]     free_code;

	assign eff_min  = (cfg.code_min == '0) ? CODE_W'(1) : cfg.code_min;
	assign in_ready = (state_q == S_IDLE);
	assign rd_issue = (state_q == S_SCAN) && (rd_cnt_q != CNT_END);
	assign rd_addr  = rd_cnt_q[IDX_W-1:0];

	rsa_ram #(
		.WIDTH(DATA_W),
		.DEPTH(SLOT_COUNT)
	) u_slot_ram (
		.clk  (clk),
		.we   (upd_we),
		.waddr(upd_idx),
		.wdata({key_q, upd_refs}),
		.re   (rd_issue),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	assign rd_owner = rd_data[DATA_W-1:REF_W];
	assign rd_refs  = rd_data[REF_W-1:0];
	assign rd_used  = in_use_q[rd_idx_s1];
	assign rd_hit   = rd_used && (rd_owner == key_q);
	// Offset is allocatable while min + offset stays at or below code_max
	assign rd_in_range = ({1'b0, eff_min} + (CODE_W + 1)'(rd_idx_s1))
		<= {1'b0, cfg.code_max};

	assign inc_refs  = (hit_refs_q == REF_MAX) ? REF_MAX : hit_refs_q + REF_W'(1);
	assign dec_refs  = (hit_refs_q == '0) ? '0 : hit_refs_q - REF_W'(1);
	assign hit_code  = eff_min + CODE_W'(hit_idx_q);
	assign free_code = eff_min + CODE_W'(free_idx_q);
	assign fire      = (state_q == S_UPDATE) && (!out_valid_q || out_ready);

	always_comb begin
		upd_we     = 1'b0;
		upd_idx    = hit_idx_q;
		upd_refs   = inc_refs;
		use_next   = in_use_q;
		res_code   = '0;
		res_status = STAT_EXHAUSTED;
		res_refs   = '0;
		if (cmd_q == CMD_ACQUIRE) begin
			priority if (found_q) begin
				upd_we     = fire;
				res_code   = hit_code;
				res_status = STAT_HIT;
				res_refs   = inc_refs;
			end else if (free_found_q) begin
				upd_we            = fire;
				upd_idx           = free_idx_q;
				upd_refs          = REF_W'(1);
				use_next[free_idx_q] = 1'b1;
				res_code          = free_code;
				res_status        = STAT_NEW;
				res_refs          = REF_W'(1);
			end else begin
				res_status = STAT_EXHAUSTED;
			end
		end else begin
			priority if (!found_q) begin
				res_status = STAT_UNKNOWN;
			end else if (dec_refs == '0) begin
				use_next[hit_idx_q] = 1'b0;
				res_code   = hit_code;
				res_status = STAT_FREED;
			end else begin
				upd_we     = fire;
				upd_refs   = dec_refs;
				res_code   = hit_code;
				res_status = STAT_HELD;
				res_refs   = dec_refs;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			rd_cnt_q     <= '0;
			rd_v_s1      <= 1'b0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			in_use_q     <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			rd_v_s1 <= rd_issue;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q      <= S_SCAN;
						rd_cnt_q     <= '0;
						found_q      <= 1'b0;
						free_found_q <= 1'b0;
					end
				end
				S_SCAN: begin
					if (rd_issue) begin
						rd_cnt_q <= rd_cnt_q + CNT_W'(1);
					end
					if (rd_v_s1) begin
						if (rd_hit && !found_q) begin
							found_q <= 1'b1;
						end
						if (!rd_used && rd_in_range && !free_found_q) begin
							free_found_q <= 1'b1;
						end
					end
					// Last read data has been checked
					if (!rd_issue && !rd_v_s1) begin
						state_q <= S_UPDATE;
					end
				end
				S_UPDATE: begin
					if (fire) begin
						state_q  <= S_IDLE;
						in_use_q <= use_next;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_addr;
		if (in_valid && in_ready) begin
			cmd_q <= command;
			key_q <= owner_key[KEY_W-1:0];
		end
		if (state_q == S_SCAN && rd_v_s1) begin
			if (rd_hit && !found_q) begin
				hit_idx_q  <= rd_idx_s1;
				hit_refs_q <= rd_refs;
			end
			if (!rd_used && rd_in_range && !free_found_q) begin
				free_idx_q <= rd_idx_s1;
			end
		end
		if (fire) begin
			code_value  <= res_code;
			status      <= res_status;
			references  <= res_refs;
			active_mask <= MASK_W'(use_next);
		end
	end

	assign out_valid = out_valid_q;

`ifndef NO_ASSERTIONS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rd_cnt_q <= CNT_END)
		else $error("scan counter ran past the slot count");

	a_idle_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !rd_v_s1)
		else $error("read still in flight while idle");

	a_new_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && cmd_q == CMD_ACQUIRE && !found_q && free_found_q)
		|-> !in_use_q[free_idx_q])
		else $error("allocated a slot already in use");

	a_fire_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q && state_q == S_IDLE)
		else $error("update did not produce a result");
`endif

endmodule

// File: src/refcounted_slot_allocator.sv
`timescale 1ns / 1ps
// Reference-counted slot allocator. For each item (acquire or release of a key)
// the engine reads the owner/count RAM one slot per cycle to find a key match
// and the lowest free slot in range, then updates the entry and the in-use
// bits in its update state once the output register is free. The result is
// held in an output register, so the next item is accepted while it waits; a
// new item is not accepted until the previous one has left the update state.
// There is no clearing pass after reset; in-use bits live in flip-flops.
// Depends on rsa_pkg, rsa_apb_regs, rsa_engine.
module refcounted_slot_allocator
	import rsa_pkg::*;
#(
	parameter int SLOT_COUNT = 32,
	parameter int KEY_BITS   = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [APB_AW-1:0]   paddr,
	input  logic [APB_DW-1:0]   pwdata,
	output logic [APB_DW-1:0]   prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                command,
	input  logic [KEY_IN_W-1:0] owner_key,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [CODE_W-1:0]   code_value,
	output logic [STAT_W-1:0]   status,
	output logic [REF_W-1:0]    references,
	output logic [MASK_W-1:0]   active_mask
);

	cfg_t cfg;

	rsa_apb_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	rsa_engine #(
		.SLOT_COUNT(SLOT_COUNT),
		.KEY_BITS  (KEY_BITS)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.owner_key  (owner_key),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.code_value (code_value),
		.status     (status),
		.references (references),
		.active_mask(active_mask)
	);

endmodule
